/* rtl/jsu_pkg.sv */
// shared types and constants for the json string unescaper
package jsu_pkg;

  // string parser phases; the unused code 7 behaves as idle
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_t;

  // result kinds carried on the output tuser
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam logic [15:0] CODE_TWO_BYTE   = 16'h0080;
  localparam logic [15:0] CODE_THREE_BYTE = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2      = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3      = 8'hE0;
  localparam logic [7:0]  UTF8_CONT       = 8'h80;
  localparam logic [5:0]  UTF8_CONT_MASK  = 6'h3F;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_QMARK     = 8'h3F;

endpackage

/* rtl/json_string_unescaper_core.sv */
// json string unescaper: parser state, result buffer and stream ports
//
// Takes text one byte per transfer and returns decoded string bytes, a
// string-complete marker or an error marker. Leading space, tab, CR and LF
// are skipped before the opening quote; escapes are decoded and \uXXXX is
// emitted as one to three UTF-8 bytes (surrogates are not combined). An
// input transfer with tlast set carries no byte and ends the text. Each
// input byte passes an input register and is decoded into a small result
// buffer of up to three entries, which drains one result per cycle while
// the output is ready; tlast on the output marks the final result caused
// by one input. The input takes one byte per cycle while the output is
// ready; a \u escape that yields two or three bytes holds the input while
// the result buffer drains.
module json_string_unescaper_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // text_ended
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] decoded_byte
  output logic [1:0] m_axis_tuser,   // [1:0] result_kind
  output logic       m_axis_tlast    // last_of_run
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;

  // parser state
  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     code_accum, code_accum_next;
  logic            hex_bad, hex_bad_next;

  // result buffer, head at entry 0
  jsu_pkg::kind_t          out_kind [jsu_pkg::MaxResults];
  logic [7:0]              out_byte [jsu_pkg::MaxResults];
  logic [jsu_pkg::CntW-1:0] out_cnt;

  // results of the byte in the input register
  jsu_pkg::kind_t           res_kind [jsu_pkg::MaxResults];
  logic [7:0]               res_byte [jsu_pkg::MaxResults];
  logic [jsu_pkg::CntW-1:0] res_cnt;

  logic        pop;
  logic        out_free;
  logic        proc;
  logic        is_hex;
  logic [3:0]  nibble;
  logic [15:0] code;
  logic        is_space;

  // escape letter to character, unknown letters become '?'
  function automatic logic [7:0] escape_char(input logic [7:0] e);
    logic [7:0] r;
    case (e)
      8'h22:   r = 8'h22;
      8'h5C:   r = 8'h5C;
      8'h2F:   r = 8'h2F;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = jsu_pkg::CH_QMARK;
    endcase
    return r;
  endfunction

  // handshakes: the buffer must be empty by the end of this cycle to load
  assign pop      = m_axis_tvalid && m_axis_tready;
  assign out_free = (out_cnt == '0) || (out_cnt == jsu_pkg::CntW'(1) && pop);
  assign proc     = in_valid && out_free;
  assign s_axis_tready = !in_valid || proc;

  assign m_axis_tvalid = (out_cnt != '0);
  assign m_axis_tdata  = out_byte[0];
  assign m_axis_tuser  = out_kind[0];
  assign m_axis_tlast  = (out_cnt == jsu_pkg::CntW'(1));

  // hex digit value; a bad digit shifts in all ones
  always_comb begin
    is_hex = 1'b1;
    nibble = 4'hF;
    if (in_byte inside {[8'h30:8'h39]}) begin
      nibble = in_byte[3:0];
    end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      nibble = in_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign code     = {code_accum[11:0], nibble};
  assign is_space = in_byte inside {8'h20, 8'h09, 8'h0D, 8'h0A};

  // next state
  always_comb begin
    phase_next      = phase;
    code_accum_next = code_accum;
    hex_bad_next    = hex_bad;
    if (in_end) begin
      phase_next      = jsu_pkg::PH_IDLE;
      code_accum_next = '0;
      hex_bad_next    = 1'b0;
    end else begin
      case (phase)
        jsu_pkg::PH_BODY: begin
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            phase_next = jsu_pkg::PH_IDLE;
          end else if (in_byte == jsu_pkg::CH_BACKSLASH) begin
            phase_next = jsu_pkg::PH_ESC;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (in_byte == jsu_pkg::CH_U) begin
            phase_next      = jsu_pkg::PH_HEX1;
            code_accum_next = '0;
            hex_bad_next    = 1'b0;
          end else begin
            phase_next = jsu_pkg::PH_BODY;
          end
        end
        jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
          code_accum_next = code;
          hex_bad_next    = hex_bad || !is_hex;
          case (phase)
            jsu_pkg::PH_HEX1: phase_next = jsu_pkg::PH_HEX2;
            jsu_pkg::PH_HEX2: phase_next = jsu_pkg::PH_HEX3;
            default:          phase_next = jsu_pkg::PH_HEX4;
          endcase
        end
        jsu_pkg::PH_HEX4: begin
          code_accum_next = '0;
          hex_bad_next    = 1'b0;
          phase_next      = (hex_bad || !is_hex) ? jsu_pkg::PH_IDLE : jsu_pkg::PH_BODY;
        end
        default: begin
          // idle, and the unused code
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            phase_next = jsu_pkg::PH_BODY;
          end else begin
            phase_next = jsu_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  // results
  always_comb begin
    res_cnt = '0;
    for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
      res_kind[i] = jsu_pkg::KIND_DATA;
      res_byte[i] = '0;
    end
    if (in_end) begin
      res_cnt     = jsu_pkg::CntW'(1);
      res_kind[0] = (phase == jsu_pkg::PH_BODY) ? jsu_pkg::KIND_DONE : jsu_pkg::KIND_ERR;
    end else begin
      case (phase)
        jsu_pkg::PH_BODY: begin
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            res_cnt     = jsu_pkg::CntW'(1);
            res_kind[0] = jsu_pkg::KIND_DONE;
          end else if (in_byte != jsu_pkg::CH_BACKSLASH) begin
            res_cnt     = jsu_pkg::CntW'(1);
            res_byte[0] = in_byte;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (in_byte != jsu_pkg::CH_U) begin
            res_cnt     = jsu_pkg::CntW'(1);
            res_byte[0] = escape_char(in_byte);
          end
        end
        jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
          res_cnt = '0;
        end
        jsu_pkg::PH_HEX4: begin
          if (hex_bad || !is_hex) begin
            res_cnt     = jsu_pkg::CntW'(1);
            res_kind[0] = jsu_pkg::KIND_ERR;
          end else if (code < jsu_pkg::CODE_TWO_BYTE) begin
            res_cnt     = jsu_pkg::CntW'(1);
            res_byte[0] = code[7:0];
          end else if (code < jsu_pkg::CODE_THREE_BYTE) begin
            res_cnt     = jsu_pkg::CntW'(2);
            res_byte[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, code[10:6]};
            res_byte[1] = jsu_pkg::UTF8_CONT | {2'b00, code[5:0] & jsu_pkg::UTF8_CONT_MASK};
          end else begin
            res_cnt     = jsu_pkg::CntW'(3);
            res_byte[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, code[15:12]};
            res_byte[1] = jsu_pkg::UTF8_CONT | {2'b00, code[11:6] & jsu_pkg::UTF8_CONT_MASK};
            res_byte[2] = jsu_pkg::UTF8_CONT | {2'b00, code[5:0] & jsu_pkg::UTF8_CONT_MASK};
          end
        end
        default: begin
          // idle: whitespace skipped, quote opens, anything else is an error
          if (!is_space && in_byte != jsu_pkg::CH_QUOTE) begin
            res_cnt     = jsu_pkg::CntW'(1);
            res_kind[0] = jsu_pkg::KIND_ERR;
          end
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_cnt    <= '0;
      phase      <= jsu_pkg::PH_IDLE;
      code_accum <= '0;
      hex_bad    <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (proc) begin
        in_valid <= 1'b0;
      end
      if (proc) begin
        out_cnt    <= res_cnt;
        phase      <= phase_next;
        code_accum <= code_accum_next;
        hex_bad    <= hex_bad_next;
      end else if (pop) begin
        out_cnt <= out_cnt - jsu_pkg::CntW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
    if (proc) begin
      for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
        out_kind[i] <= res_kind[i];
        out_byte[i] <= res_byte[i];
      end
    end else if (pop) begin
      // shift the next result to the head
      for (int i = 0; i < jsu_pkg::MaxResults - 1; i++) begin
        out_kind[i] <= out_kind[i+1];
        out_byte[i] <= out_byte[i+1];
      end
    end
  end

endmodule

/* rtl/jsu_checker.sv */
// port checker for the json string unescaper, bound into the core module
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // markers are always the only result of their input and carry a zero byte
  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != jsu_pkg::KIND_DATA |->
      m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("marker result not alone or byte not zero");

  // a run continues without a gap once started
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a run of results");

  // multi-byte runs are utf-8: continuation bytes follow
  a_run_cont_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tuser == jsu_pkg::KIND_DATA && m_axis_tdata[7:6] == 2'b10)
    else $error("run continuation is not a utf-8 continuation byte");

endmodule

bind json_string_unescaper_core jsu_checker u_jsu_checker (.*);

/* bench/json_string_unescaper_core_test.sv */
// self-checking bench for the json string unescaper core
`timescale 1ns / 1ps

module json_string_unescaper_core_test;

  localparam int unsigned RandomBytes = 280;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned CalmFrom    = 140;
  localparam int unsigned CalmTo      = 240;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       ended;
    logic       hold;     // wait for all decoded output before offering
  } text_item_t;

  typedef struct packed {
    jsu_pkg::kind_t kind;
    logic [7:0]     data;
    logic           last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  text_item_t text_queue [$];
  decoded_t   due_results [$];
  int unsigned sent_count = 0;
  int unsigned got_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned faults = 0;

  // predictor state
  jsu_pkg::phase_t text_phase = jsu_pkg::PH_IDLE;
  logic [15:0]     code_acc = '0;
  logic            hex_bad = 1'b0;

  logic [7:0] blanks [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
  logic [7:0] esc_letters [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH,
                                  "/", "b", "f", "n", "r", "t"};

  json_string_unescaper_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // works out the decoded output of one accepted text transfer
  function automatic void decode_text(input logic [7:0] c, input logic ended);
    jsu_pkg::kind_t kinds [3];
    logic [7:0]     bytes_out [3];
    int             n;
    logic [3:0]     nib;
    logic [15:0]    code;
    decoded_t       r;
    n = 0;
    if (ended) begin
      kinds[0] = (text_phase == jsu_pkg::PH_BODY) ? jsu_pkg::KIND_DONE : jsu_pkg::KIND_ERR;
      bytes_out[0] = '0;
      n = 1;
      text_phase = jsu_pkg::PH_IDLE;
      code_acc = '0;
      hex_bad = 1'b0;
    end else begin
      case (text_phase)
        jsu_pkg::PH_BODY: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            kinds[0] = jsu_pkg::KIND_DONE;
            bytes_out[0] = '0;
            n = 1;
            text_phase = jsu_pkg::PH_IDLE;
          end else if (c == jsu_pkg::CH_BACKSLASH) begin
            text_phase = jsu_pkg::PH_ESC;
          end else begin
            kinds[0] = jsu_pkg::KIND_DATA;
            bytes_out[0] = c;
            n = 1;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (c == jsu_pkg::CH_U) begin
            text_phase = jsu_pkg::PH_HEX1;
            code_acc = '0;
            hex_bad = 1'b0;
          end else begin
            kinds[0] = jsu_pkg::KIND_DATA;
            case (c)
              jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, "/": bytes_out[0] = c;
              "b": bytes_out[0] = 8'h08;
              "f": bytes_out[0] = 8'h0C;
              "n": bytes_out[0] = CH_LF;
              "r": bytes_out[0] = CH_CR;
              "t": bytes_out[0] = CH_TAB;
              default: bytes_out[0] = jsu_pkg::CH_QMARK;
            endcase
            n = 1;
            text_phase = jsu_pkg::PH_BODY;
          end
        end
        jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4: begin
          if (c >= "0" && c <= "9") nib = 4'(c - "0");
          else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
          else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
          else begin
            nib = 4'hF;
            hex_bad = 1'b1;
          end
          code_acc = {code_acc[11:0], nib};
          if (text_phase != jsu_pkg::PH_HEX4) begin
            text_phase = jsu_pkg::phase_t'(text_phase + 3'd1);
          end else if (hex_bad) begin
            kinds[0] = jsu_pkg::KIND_ERR;
            bytes_out[0] = '0;
            n = 1;
            text_phase = jsu_pkg::PH_IDLE;
            code_acc = '0;
            hex_bad = 1'b0;
          end else begin
            code = code_acc;
            kinds = '{jsu_pkg::KIND_DATA, jsu_pkg::KIND_DATA, jsu_pkg::KIND_DATA};
            if (code < jsu_pkg::CODE_TWO_BYTE) begin
              bytes_out[0] = code[7:0];
              n = 1;
            end else if (code < jsu_pkg::CODE_THREE_BYTE) begin
              bytes_out[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, code[10:6]};
              bytes_out[1] = jsu_pkg::UTF8_CONT |
                             {2'b00, code[5:0] & jsu_pkg::UTF8_CONT_MASK};
              n = 2;
            end else begin
              bytes_out[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, code[15:12]};
              bytes_out[1] = jsu_pkg::UTF8_CONT |
                             {2'b00, code[11:6] & jsu_pkg::UTF8_CONT_MASK};
              bytes_out[2] = jsu_pkg::UTF8_CONT |
                             {2'b00, code[5:0] & jsu_pkg::UTF8_CONT_MASK};
              n = 3;
            end
            text_phase = jsu_pkg::PH_BODY;
            code_acc = '0;
            hex_bad = 1'b0;
          end
        end
        default: begin
          // idle: skip blanks, open on a quote, anything else is an error
          if (c == jsu_pkg::CH_QUOTE) begin
            text_phase = jsu_pkg::PH_BODY;
          end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)) begin
            kinds[0] = jsu_pkg::KIND_ERR;
            bytes_out[0] = '0;
            n = 1;
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      r.kind = kinds[i];
      r.data = bytes_out[i];
      r.last = (i == n - 1);
      due_results.push_back(r);
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic ended = 1'b0,
                           input logic hold = 1'b0);
    text_item_t it;
    it.text_byte = b;
    it.ended = ended;
    it.hold = hold;
    text_queue.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // sender: offers the head of the text queue
  always @(posedge clk) begin
    logic took;
    logic offer;
    took = s_axis_tvalid && s_axis_tready;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (took) begin
        void'(text_queue.pop_front());
        sent_count++;
      end
      offer = 1'b0;
      if (text_queue.size() != 0) begin
        if (s_axis_tvalid && !took) offer = 1'b1;
        else if (text_queue[0].hold && (due_results.size() != 0 || took)) offer = 1'b0;
        else offer = (sent_count >= CalmFrom && sent_count < CalmTo) ||
                     ($urandom_range(99) >= 20);
      end
      s_axis_tvalid <= offer;
      if (offer) begin
        s_axis_tdata <= text_queue[0].text_byte;
        s_axis_tlast <= text_queue[0].ended;
      end
    end
  end

  // receiver: predicts on input transfers, checks output transfers
  always @(posedge clk) begin
    logic took_in;
    logic took_out;
    decoded_t seen;
    decoded_t want;
    took_in = s_axis_tvalid && s_axis_tready;
    took_out = m_axis_tvalid && m_axis_tready;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (took_in) decode_text(s_axis_tdata, s_axis_tlast);
      if (took_out) begin
        got_count++;
        seen.kind = jsu_pkg::kind_t'(m_axis_tuser);
        seen.data = m_axis_tdata;
        seen.last = m_axis_tlast;
        if (due_results.size() == 0) begin
          faults++;
          $display("%0t: unexpected result, expected none, actual kind %0d byte %h last %b",
                   $time, seen.kind, seen.data, seen.last);
        end else begin
          want = due_results.pop_front();
          if (seen.kind !== want.kind || seen.data !== want.data ||
              seen.last !== want.last) begin
            faults++;
            $display("%0t: mismatch, kind/byte/last expected %0d/%h/%b, actual %0d/%h/%b",
                     $time, want.kind, want.data, want.last,
                     seen.kind, seen.data, seen.last);
          end
        end
      end
      m_axis_tready <= (got_count >= CalmFrom && got_count < CalmTo) ||
                       ($urandom_range(99) >= 20);
      if (took_in || took_out) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned target;
    int unsigned pick;
    int unsigned bad_pos;
    logic [7:0]  b;
    logic [3:0]  nib;
    logic [15:0] code;
    logic        spoil;

    // blanks while idle are skipped, anything else is an error
    push_byte(CH_SPACE);
    push_byte(CH_TAB);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(8'hFF);
    push_byte(8'($urandom), 1'b1);      // end of text while idle
    // body extremes, unknown escape, three-byte code point, closing quote
    push_byte(jsu_pkg::CH_QUOTE);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(jsu_pkg::CH_BACKSLASH);
    push_byte("q");
    push_byte(jsu_pkg::CH_BACKSLASH);
    push_text("uFFFF");
    push_byte(jsu_pkg::CH_QUOTE);
    // bad hex digit, reported after the fourth digit; sender waits for drain
    push_byte(jsu_pkg::CH_QUOTE, 1'b0, 1'b1);
    push_byte(jsu_pkg::CH_BACKSLASH);
    push_text("u12g4");
    // end of text after a backslash, inside the hex digits, and in the body
    push_byte(jsu_pkg::CH_QUOTE);
    push_byte(jsu_pkg::CH_BACKSLASH);
    push_byte(8'($urandom), 1'b1);
    push_byte(jsu_pkg::CH_QUOTE);
    push_byte(jsu_pkg::CH_BACKSLASH);
    push_text("u0");
    push_byte(8'($urandom), 1'b1);
    push_byte(jsu_pkg::CH_QUOTE);
    push_byte(8'($urandom), 1'b1);

    target = text_queue.size() + RandomBytes;
    while (text_queue.size() < target) begin
      if ($urandom_range(99) < 75) begin
        // quoted string with random content, at times with a bad hex digit or cut off by end of text
        repeat ($urandom_range(2)) push_byte(blanks[2'($urandom_range(3))]);
        push_byte(jsu_pkg::CH_QUOTE, 1'b0, $urandom_range(14) == 0);
        repeat ($urandom_range(8)) begin
          pick = $urandom_range(99);
          if (pick < 45) begin
            do b = 8'($urandom);
            while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BACKSLASH);
            push_byte(b);
          end else if (pick < 70) begin
            push_byte(jsu_pkg::CH_BACKSLASH);
            if ($urandom_range(9) < 8) b = esc_letters[3'($urandom_range(7))];
            else do b = 8'($urandom); while (b == jsu_pkg::CH_U);
            push_byte(b);
          end else begin
            case ($urandom_range(2))
              0: code = 16'($urandom_range(16'h007F));
              1: code = 16'($urandom_range(16'h07FF, 16'h0080));
              default: code = 16'($urandom_range(16'hFFFF, 16'h0800));
            endcase
            spoil = ($urandom_range(9) == 0);
            bad_pos = $urandom_range(3);
            push_byte(jsu_pkg::CH_BACKSLASH);
            push_byte(jsu_pkg::CH_U);
            for (int i = 3; i >= 0; i--) begin
              nib = code[i*4 +: 4];
              if (nib < 10) b = "0" + nib;
              else b = ($urandom_range(1) ? "A" : "a") + nib - 8'd10;
              if (spoil && bad_pos == i) begin
                do b = 8'($urandom);
                while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                       (b >= "A" && b <= "F"));
              end
              push_byte(b);
            end
          end
        end
        if ($urandom_range(5) == 0) push_byte(8'($urandom), 1'b1);
        else push_byte(jsu_pkg::CH_QUOTE);
      end else begin
        // noise, with the odd end-of-text marker
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom), $urandom_range(4) == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (text_queue.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (faults == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/jsu_pkg.sv
rtl/json_string_unescaper_core.sv
rtl/jsu_checker.sv
bench/json_string_unescaper_core_test.sv
